// ===== sv/pixel_symbol_index_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel symbol index lookup block
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_SYMBOL_INDEX_LOOKUP_TOP_MACROS_SVH
`define PIXEL_SYMBOL_INDEX_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication
`define PSIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PSIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/psil_pkg.sv =====
// ----------------------------------------------------------------------------
// psil_pkg
// Types and fixed constants of the pixel symbol index lookup block.
// ----------------------------------------------------------------------------
package psil_pkg;

	// Field widths
	localparam int SYM_W    = 32;
	localparam int ENTRY_W  = 8;
	localparam int INDEX_W  = 8;
	localparam int POS_W    = 24;
	localparam int COL_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFGA_W   = 2;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 32;

	// Most characters a symbol may carry; compare width saturates here
	localparam int MAX_SYMBOL_CHARS = 4;
	localparam int SYM_TOP = (MAX_SYMBOL_CHARS > 4) ? 4 :
		((MAX_SYMBOL_CHARS < 1) ? 1 : MAX_SYMBOL_CHARS);

	// Most entries a lookup can search; a result index stays below it
	localparam int INDEX_LIMIT = 256;

	// Request kinds on s_tuser
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Configuration register indexes
	localparam logic [CFGA_W-1:0] REG_SYMBOL_CHARS = 2'd0;
	localparam logic [CFGA_W-1:0] REG_COLOR_COUNT  = 2'd1;
	localparam logic [CFGA_W-1:0] REG_ROW_WIDTH    = 2'd2;

	typedef logic [SYM_W-1:0]   symbol_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [POS_W-1:0]   position_t;
	typedef logic [COL_W-1:0]   column_t;

endpackage

// ===== sv/pixel_symbol_index_lookup_top.sv =====
// ----------------------------------------------------------------------------
// pixel_symbol_index_lookup_top
// Palette symbol table with first-match lookup, pixel position and row end.
// ----------------------------------------------------------------------------
// A load word (s_tuser = 0) writes its symbol into the table entry named by
// entry_index; entries at or past TABLE_DEPTH are dropped. A lookup word
// (s_tuser = 1) scans the table from entry 0 through the single read port of
// the table RAM, one entry per cycle, and compares the low symbol_chars bytes.
// A hit ends the scan at the first matching entry; a miss is found once all
// capped color_count entries are read, or with no read when the capped count
// is zero. One lookup is in flight at a time; the next word is taken as soon
// as the result sits in the output register, even if it is not yet taken.
// Table entries hold no reset value and must be loaded before they are
// searched. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module pixel_symbol_index_lookup_top
	import psil_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [CFGA_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata,
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_DW-1:0]    s_tdata,   // [7:0] entry_index, [39:8] symbol_bytes
	input  logic                s_tuser,   // [0] req_type
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_DW-1:0]   m_tdata,   // [7:0] color_index, [31:8] pixel_position
	output logic                m_tuser,   // [0] miss
	output logic                m_tlast    // row_end
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LIMIT_CAP = (TABLE_DEPTH < INDEX_LIMIT) ? TABLE_DEPTH : INDEX_LIMIT;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	// Configuration registers
	logic [2:0]  symbol_chars_q;
	logic [8:0]  color_count_q;
	column_t     row_width_q;

	logic [1:0]  state_q;
	logic [8:0]  iss_q;
	logic        rd_valid_s1;
	index_t      idx_s1;
	symbol_t     sym_q;
	index_t      res_idx_q;
	logic        res_miss_q;
	position_t   pos_q;
	column_t     col_q;

	logic        m_tvalid_q;
	index_t      m_idx_q;
	position_t   m_pos_q;
	logic        m_miss_q;
	logic        m_last_q;

	logic        in_acc;
	logic        is_load;
	logic        tbl_we;
	index_t      in_entry;
	symbol_t     in_sym;
	logic        rd_en;
	symbol_t     rd_data;
	symbol_t     mask;
	logic [2:0]  n_chars;
	logic [8:0]  limit;
	logic        match;
	logic        hit_now;
	logic        miss_now;
	logic        out_load;
	column_t     width_eff;
	logic [COL_W:0] col_inc;
	logic        last;

	// Unpack the request word
	assign in_entry = s_tdata[INDEX_W-1:0];
	assign in_sym   = s_tdata[INDEX_W +: SYM_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign is_load  = (s_tuser == REQ_LOAD);
	assign tbl_we   = in_acc && is_load && (32'(in_entry) < TABLE_DEPTH);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_chars_q <= 3'd1;
			color_count_q  <= 9'd1;
			row_width_q    <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SYMBOL_CHARS: symbol_chars_q <= cfg_wdata[2:0];
				REG_COLOR_COUNT:  color_count_q  <= cfg_wdata[8:0];
				REG_ROW_WIDTH:    row_width_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Saturate the character count and build the byte compare mask
	always_comb begin
		n_chars = symbol_chars_q;
		if (n_chars < 3'd1) begin
			n_chars = 3'd1;
		end
		if (32'(n_chars) > SYM_TOP) begin
			n_chars = 3'(SYM_TOP);
		end
		for (int b = 0; b < 4; b++) begin
			mask[8*b +: 8] = {8{32'(b) < 32'(n_chars)}};
		end
	end

	// Cap the entry count at the table and index range
	assign limit = (32'(color_count_q) > LIMIT_CAP) ? 9'(LIMIT_CAP) : color_count_q;

	// Symbol table; loads happen only when idle and reads only while scanning,
	// so the two ports never touch the same entry in one cycle
	psil_ram #(
		.WIDTH(SYM_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(in_entry)),
		.wdata (in_sym),
		.re    (rd_en),
		.raddr (AW'(iss_q)),
		.rdata (rd_data)
	);

	// Compare the returning entry; stop issuing on the first hit
	assign match    = ((rd_data ^ sym_q) & mask) == '0;
	assign hit_now  = (state_q == ST_SCAN) && rd_valid_s1 && match;
	assign miss_now = (state_q == ST_SCAN) && !rd_valid_s1 && (iss_q == limit);
	assign rd_en    = (state_q == ST_SCAN) && (iss_q < limit) && !hit_now;
	assign out_load = (state_q == ST_WAIT) && (!m_tvalid_q || m_tready);

	// Sequence the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !is_load) begin
						state_q <= ST_SCAN;
						iss_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (hit_now || miss_now) begin
						state_q <= ST_WAIT;
					end else if (rd_en) begin
						iss_q <= iss_q + 9'd1;
					end
				end
				ST_WAIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the symbol, the index in flight and the scan result
	always_ff @(posedge clk) begin
		if (in_acc && !is_load) begin
			sym_q <= in_sym;
		end
		if (rd_en) begin
			idx_s1 <= iss_q[INDEX_W-1:0];
		end
		if (hit_now) begin
			res_idx_q  <= idx_s1;
			res_miss_q <= 1'b0;
		end else if (miss_now) begin
			res_idx_q  <= '0;
			res_miss_q <= 1'b1;
		end
	end

	// Row end against the effective row width
	assign width_eff = (row_width_q == '0) ? 16'd1 : row_width_q;
	assign col_inc   = {1'b0, col_q} + 17'd1;
	assign last      = col_inc >= {1'b0, width_eff};

	// Advance pixel and column counters as each result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
		end else if (out_load) begin
			pos_q <= pos_q + 24'd1;
			col_q <= last ? '0 : col_inc[COL_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_idx_q  <= res_idx_q;
			m_miss_q <= res_miss_q;
			m_pos_q  <= pos_q;
			m_last_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_pos_q, m_idx_q};
	assign m_tuser  = m_miss_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== sv/psil_ram.sv =====
// ----------------------------------------------------------------------------
// psil_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module psil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/psil_checker.sv =====
// ----------------------------------------------------------------------------
// psil_checker
// Port-level checks of the pixel symbol index lookup block, bound to the top.
// ----------------------------------------------------------------------------
`include "pixel_symbol_index_lookup_top_macros.svh"

module psil_checker
	import psil_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_DW-1:0] m_tdata,
	input  logic              m_tuser,
	input  logic              m_tlast
);

	logic acc_lookup;
	logic acc_load;

	assign acc_lookup = s_tvalid && s_tready && (s_tuser == REQ_LOOKUP);
	assign acc_load   = s_tvalid && s_tready && (s_tuser == REQ_LOAD);

	// A stalled result word holds
	`PSIL_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")

	// A lookup blocks further requests while it scans
	`PSIL_ASSERT_NXT(a_lookup_busy, clk, arst_n, acc_lookup, !s_tready, "request taken during a scan")

	// A load leaves the block ready for the next word
	`PSIL_ASSERT_NXT(a_load_ready, clk, arst_n, acc_load, s_tready, "load stalled the request side")

	// A miss reports index zero
	`PSIL_ASSERT_IMP(a_miss_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata[INDEX_W-1:0] == '0, "miss with nonzero index")

endmodule

bind pixel_symbol_index_lookup_top psil_checker u_psil_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
